@@ rtl/lrp_pkg.sv @@
// Shared types, sizes and codes of the LR table parser driver.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package lrp_pkg;

  // Table sizes
  localparam int NUM_STATES       = 256;
  localparam int NUM_TERMINALS    = 64;
  localparam int NUM_NONTERMINALS = 64;
  localparam int NUM_RULES        = 256;
  localparam int STACK_DEPTH      = 64;
  localparam int REDUCE_LIMIT     = 63;

  // Field widths of the request and result payloads
  localparam int MODE_W  = 2;
  localparam int STATE_W = 8;
  localparam int SYM_W   = 6;
  localparam int KIND_W  = 2;
  localparam int LEN_W   = 4;
  localparam int EVENT_W = 3;

  // Store entry widths
  localparam int ACT_W  = KIND_W + STATE_W;
  localparam int GOTO_W = 1 + STATE_W;
  localparam int RULE_W = LEN_W + SYM_W;

  // Store depths and address widths
  localparam int ACT_DEPTH  = NUM_STATES * NUM_TERMINALS;
  localparam int GOTO_DEPTH = NUM_STATES * NUM_NONTERMINALS;
  localparam int ACT_AW     = $clog2(ACT_DEPTH);
  localparam int GOTO_AW    = $clog2(GOTO_DEPTH);
  localparam int TAB_AW     = (ACT_AW > GOTO_AW) ? ACT_AW : GOTO_AW;
  localparam int RULE_DEPTH = (NUM_RULES > 1) ? NUM_RULES : 2;
  localparam int RULE_AW    = $clog2(RULE_DEPTH);
  localparam int SP_AW      = $clog2(STACK_DEPTH);
  localparam int LVL_W      = $clog2(STACK_DEPTH + 1);
  localparam int RED_W      = $clog2(REDUCE_LIMIT + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_ACT_WR  = 2'd0,
    MODE_GOTO_WR = 2'd1,
    MODE_RULE_WR = 2'd2,
    MODE_TOKEN   = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ERROR  = 2'd0,
    KIND_SHIFT  = 2'd1,
    KIND_REDUCE = 2'd2,
    KIND_ACCEPT = 2'd3
  } kind_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_SHIFT   = 3'd0,
    EV_REDUCE  = 3'd1,
    EV_ACCEPT  = 3'd2,
    EV_NOACT   = 3'd3,
    EV_NOGOTO  = 3'd4,
    EV_OVER    = 3'd5,
    EV_UNDER   = 3'd6,
    EV_LIMIT   = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACT,
    ST_RULE,
    ST_BELOW,
    ST_GOTO
  } seq_state_t;

  // Request to the shared table index unit
  typedef struct packed {
    logic [STATE_W-1:0] row;
    logic [SYM_W-1:0]   col;
    logic               sel_goto;
  } idx_req_t;

  typedef struct packed {
    logic [TAB_AW-1:0] addr;
    logic              ok;
  } idx_rsp_t;

  // Memory port controls from the sequencer
  typedef struct packed {
    logic               act_we;
    logic               act_re;
    logic [ACT_AW-1:0]  act_addr;
    logic [ACT_W-1:0]   act_wd;
    logic               goto_we;
    logic               goto_re;
    logic [GOTO_AW-1:0] goto_addr;
    logic [GOTO_W-1:0]  goto_wd;
    logic               rule_we;
    logic               rule_re;
    logic [RULE_AW-1:0] rule_addr;
    logic [RULE_W-1:0]  rule_wd;
    logic               stk_we;
    logic               stk_re;
    logic [SP_AW-1:0]   stk_addr;
    logic [STATE_W-1:0] stk_wd;
  } mem_ctl_t;

  typedef struct packed {
    logic [ACT_W-1:0]   act_rd;
    logic [GOTO_W-1:0]  goto_rd;
    logic [RULE_W-1:0]  rule_rd;
    logic [STATE_W-1:0] stk_rd;
  } mem_rd_t;

endpackage

@@ rtl/lr_table_parser_driver_top.sv @@
// Top level of the LR table parser driver: sequencer, shared index unit, stores.
// Depends on lrp_pkg, lrp_ram, lrp_index and lrp_seq.
`timescale 1ns / 1ps
//
//  Channel   Handshake            Payload
//  -------   ------------------   ---------------------------------------------
//  in        in_valid / in_ready  mode, table_state, table_symbol, action_kind,
//                                 action_target, goto_target, goto_valid,
//                                 rule_index, rule_length, rule_lhs, token_kind
//  out       out_valid/out_ready  event_res, number, top_state, last
//
//  A table-load request writes its store entry at acceptance. A token request
//  reads its action, then per reduction the rule, the stack entry below, the
//  goto and the action again, one after another through the single-port stores
//  and the shared index unit; in_ready is low until the token's final result
//  has been loaded into the result register.
//  Reset leaves the stack holding only the bottom state zero; the stores need
//  no clearing pass. A result waiting on out_ready stalls only the step that
//  would produce the next result; a new request is taken meanwhile.
//

module lr_table_parser_driver_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lrp_pkg::MODE_W-1:0]    mode,
  input  logic [lrp_pkg::STATE_W-1:0]   table_state,
  input  logic [lrp_pkg::SYM_W-1:0]     table_symbol,
  input  logic [lrp_pkg::KIND_W-1:0]    action_kind,
  input  logic [lrp_pkg::STATE_W-1:0]   action_target,
  input  logic [lrp_pkg::STATE_W-1:0]   goto_target,
  input  logic                          goto_valid,
  input  logic [lrp_pkg::STATE_W-1:0]   rule_index,
  input  logic [lrp_pkg::LEN_W-1:0]     rule_length,
  input  logic [lrp_pkg::SYM_W-1:0]     rule_lhs,
  input  logic [lrp_pkg::SYM_W-1:0]     token_kind,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lrp_pkg::EVENT_W-1:0]   event_res,
  output logic [lrp_pkg::STATE_W-1:0]   number,
  output logic [lrp_pkg::STATE_W-1:0]   top_state,
  output logic                          last
);

  lrp_pkg::idx_req_t idx_req;
  lrp_pkg::idx_rsp_t idx_rsp;
  lrp_pkg::mem_ctl_t mem_ctl;
  lrp_pkg::mem_rd_t  mem_rd;

  // Sequencer: owns the stack pointer, top-of-stack copy and result register
  lrp_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .table_state   (table_state),
    .table_symbol  (table_symbol),
    .action_kind   (action_kind),
    .action_target (action_target),
    .goto_target   (goto_target),
    .goto_valid    (goto_valid),
    .rule_index    (rule_index),
    .rule_length   (rule_length),
    .rule_lhs      (rule_lhs),
    .token_kind    (token_kind),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_res     (event_res),
    .number        (number),
    .top_state     (top_state),
    .last          (last),
    .idx_req       (idx_req),
    .idx_rsp       (idx_rsp),
    .mem_ctl       (mem_ctl),
    .mem_rd        (mem_rd)
  );

  // One index multiply-add serves loads, action lookups and goto lookups
  lrp_index u_index (
    .idx_req (idx_req),
    .idx_rsp (idx_rsp)
  );

  // Action table: kind and target per state and terminal
  lrp_ram #(
    .WIDTH (lrp_pkg::ACT_W),
    .DEPTH (lrp_pkg::ACT_DEPTH)
  ) u_act_ram (
    .clk  (clk),
    .we   (mem_ctl.act_we),
    .re   (mem_ctl.act_re),
    .addr (mem_ctl.act_addr),
    .wd   (mem_ctl.act_wd),
    .rd   (mem_rd.act_rd)
  );

  // Goto table: valid bit and target per state and nonterminal
  lrp_ram #(
    .WIDTH (lrp_pkg::GOTO_W),
    .DEPTH (lrp_pkg::GOTO_DEPTH)
  ) u_goto_ram (
    .clk  (clk),
    .we   (mem_ctl.goto_we),
    .re   (mem_ctl.goto_re),
    .addr (mem_ctl.goto_addr),
    .wd   (mem_ctl.goto_wd),
    .rd   (mem_rd.goto_rd)
  );

  // Rule table: length and left-hand nonterminal per rule
  lrp_ram #(
    .WIDTH (lrp_pkg::RULE_W),
    .DEPTH (lrp_pkg::RULE_DEPTH)
  ) u_rule_ram (
    .clk  (clk),
    .we   (mem_ctl.rule_we),
    .re   (mem_ctl.rule_re),
    .addr (mem_ctl.rule_addr),
    .wd   (mem_ctl.rule_wd),
    .rd   (mem_rd.rule_rd)
  );

  // State stack; the bottom entry is never written and reads as state zero
  lrp_ram #(
    .WIDTH (lrp_pkg::STATE_W),
    .DEPTH (lrp_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (mem_ctl.stk_we),
    .re   (mem_ctl.stk_re),
    .addr (mem_ctl.stk_addr),
    .wd   (mem_ctl.stk_wd),
    .rd   (mem_rd.stk_rd)
  );

endmodule

@@ rtl/lrp_ram.sv @@
// Generic single-port RAM with registered read data that holds between reads.
// No dependencies.
`timescale 1ns / 1ps

module lrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wd,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    if (re) begin
      rd <= mem[addr];
    end
  end

endmodule

@@ rtl/lrp_index.sv @@
// Shared table index unit: row times column count plus column, with range check.
// Depends on lrp_pkg.
`timescale 1ns / 1ps

module lrp_index (
  input  lrp_pkg::idx_req_t idx_req,
  output lrp_pkg::idx_rsp_t idx_rsp
);

  logic [lrp_pkg::TAB_AW-1:0] ncols;
  logic                       row_ok;
  logic                       col_ok;

  always_comb begin
    if (idx_req.sel_goto) begin
      ncols  = lrp_pkg::TAB_AW'(lrp_pkg::NUM_NONTERMINALS);
      col_ok = 32'(idx_req.col) < lrp_pkg::NUM_NONTERMINALS;
    end else begin
      ncols  = lrp_pkg::TAB_AW'(lrp_pkg::NUM_TERMINALS);
      col_ok = 32'(idx_req.col) < lrp_pkg::NUM_TERMINALS;
    end
    row_ok       = 32'(idx_req.row) < lrp_pkg::NUM_STATES;
    idx_rsp.addr = lrp_pkg::TAB_AW'(idx_req.row) * ncols + lrp_pkg::TAB_AW'(idx_req.col);
    idx_rsp.ok   = row_ok && col_ok;
  end

endmodule

@@ rtl/lrp_seq.sv @@
// Parse sequencer: request intake, action/rule/stack/goto steps, result register.
// Depends on lrp_pkg; drives the stores and the shared index unit.
`timescale 1ns / 1ps

module lrp_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lrp_pkg::MODE_W-1:0]    mode,
  input  logic [lrp_pkg::STATE_W-1:0]   table_state,
  input  logic [lrp_pkg::SYM_W-1:0]     table_symbol,
  input  logic [lrp_pkg::KIND_W-1:0]    action_kind,
  input  logic [lrp_pkg::STATE_W-1:0]   action_target,
  input  logic [lrp_pkg::STATE_W-1:0]   goto_target,
  input  logic                          goto_valid,
  input  logic [lrp_pkg::STATE_W-1:0]   rule_index,
  input  logic [lrp_pkg::LEN_W-1:0]     rule_length,
  input  logic [lrp_pkg::SYM_W-1:0]     rule_lhs,
  input  logic [lrp_pkg::SYM_W-1:0]     token_kind,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lrp_pkg::EVENT_W-1:0]   event_res,
  output logic [lrp_pkg::STATE_W-1:0]   number,
  output logic [lrp_pkg::STATE_W-1:0]   top_state,
  output logic                          last,
  output lrp_pkg::idx_req_t             idx_req,
  input  lrp_pkg::idx_rsp_t             idx_rsp,
  output lrp_pkg::mem_ctl_t             mem_ctl,
  input  lrp_pkg::mem_rd_t              mem_rd
);

  lrp_pkg::seq_state_t state, state_next;

  logic [lrp_pkg::LVL_W-1:0]   level, level_next;
  logic [lrp_pkg::STATE_W-1:0] top, top_next;
  logic [lrp_pkg::SYM_W-1:0]   tok, tok_next;
  logic [lrp_pkg::RED_W-1:0]   red_cnt, red_cnt_next;
  logic [lrp_pkg::STATE_W-1:0] rule_num, rule_num_next;
  logic [lrp_pkg::SYM_W-1:0]   lhs, lhs_next;
  logic [lrp_pkg::STATE_W-1:0] below, below_next;
  logic                        below_zero, below_zero_next;
  logic                        look_ok, look_ok_next;

  logic                        emit;
  lrp_pkg::event_t             emit_event;
  lrp_pkg::event_t             out_event;
  logic [lrp_pkg::STATE_W-1:0] emit_number;
  logic [lrp_pkg::STATE_W-1:0] emit_top;
  logic                        emit_last;
  logic                        stack_clear;
  logic                        slot_free;

  lrp_pkg::mode_t              in_mode;
  lrp_pkg::kind_t              act_kind;
  logic [lrp_pkg::STATE_W-1:0] act_tgt;
  logic [lrp_pkg::LEN_W-1:0]   rule_len;
  logic [lrp_pkg::LVL_W-1:0]   pop_level;
  logic [lrp_pkg::STATE_W-1:0] below_val;
  logic                        g_ok;
  logic [lrp_pkg::STATE_W-1:0] g_tgt;

  assign in_ready  = (state == lrp_pkg::ST_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign in_mode   = lrp_pkg::mode_t'(mode);
  assign act_kind  = look_ok ? lrp_pkg::kind_t'(mem_rd.act_rd[lrp_pkg::ACT_W-1 -: lrp_pkg::KIND_W])
                             : lrp_pkg::KIND_ERROR;
  assign act_tgt   = mem_rd.act_rd[lrp_pkg::STATE_W-1:0];
  assign rule_len  = mem_rd.rule_rd[lrp_pkg::RULE_W-1 -: lrp_pkg::LEN_W];
  assign pop_level = level - lrp_pkg::LVL_W'(rule_len);
  assign below_val = below_zero ? '0 : mem_rd.stk_rd;
  assign g_ok      = look_ok && mem_rd.goto_rd[lrp_pkg::GOTO_W-1];
  assign g_tgt     = mem_rd.goto_rd[lrp_pkg::STATE_W-1:0];

  assign event_res = out_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    level_next      = level;
    top_next        = top;
    tok_next        = tok;
    red_cnt_next    = red_cnt;
    rule_num_next   = rule_num;
    lhs_next        = lhs;
    below_next      = below;
    below_zero_next = below_zero;
    look_ok_next    = look_ok;
    emit            = 1'b0;
    emit_event      = lrp_pkg::EV_SHIFT;
    emit_number     = top;
    emit_top        = '0;
    emit_last       = 1'b1;
    stack_clear     = 1'b0;
    mem_ctl         = '0;
    idx_req.row      = table_state;
    idx_req.col      = table_symbol;
    idx_req.sel_goto = (in_mode == lrp_pkg::MODE_GOTO_WR);

    unique case (state)
      lrp_pkg::ST_IDLE: begin
        if (in_mode == lrp_pkg::MODE_TOKEN) begin
          idx_req.row = top;
          idx_req.col = token_kind;
        end
        if (in_valid) begin
          unique case (in_mode)
            lrp_pkg::MODE_ACT_WR: begin
              mem_ctl.act_we   = idx_rsp.ok;
              mem_ctl.act_addr = idx_rsp.addr[lrp_pkg::ACT_AW-1:0];
              mem_ctl.act_wd   = {action_kind, action_target};
            end
            lrp_pkg::MODE_GOTO_WR: begin
              mem_ctl.goto_we   = idx_rsp.ok;
              mem_ctl.goto_addr = idx_rsp.addr[lrp_pkg::GOTO_AW-1:0];
              mem_ctl.goto_wd   = {goto_valid, goto_target};
            end
            lrp_pkg::MODE_RULE_WR: begin
              mem_ctl.rule_we   = 32'(rule_index) < lrp_pkg::NUM_RULES;
              mem_ctl.rule_addr = lrp_pkg::RULE_AW'(rule_index);
              mem_ctl.rule_wd   = {rule_length, rule_lhs};
            end
            lrp_pkg::MODE_TOKEN: begin
              mem_ctl.act_re   = 1'b1;
              mem_ctl.act_addr = idx_rsp.addr[lrp_pkg::ACT_AW-1:0];
              look_ok_next     = idx_rsp.ok;
              tok_next         = token_kind;
              red_cnt_next     = '0;
              state_next       = lrp_pkg::ST_ACT;
            end
          endcase
        end
      end

      lrp_pkg::ST_ACT: begin
        unique case (act_kind)
          lrp_pkg::KIND_SHIFT: begin
            if (slot_free) begin
              emit       = 1'b1;
              state_next = lrp_pkg::ST_IDLE;
              if (32'(level) >= lrp_pkg::STACK_DEPTH) begin
                emit_event  = lrp_pkg::EV_OVER;
                stack_clear = 1'b1;
              end else begin
                mem_ctl.stk_we   = 1'b1;
                mem_ctl.stk_addr = lrp_pkg::SP_AW'(level);
                mem_ctl.stk_wd   = act_tgt;
                level_next       = level + lrp_pkg::LVL_W'(1);
                top_next         = act_tgt;
                emit_event       = lrp_pkg::EV_SHIFT;
                emit_number      = act_tgt;
                emit_top         = act_tgt;
              end
            end
          end
          lrp_pkg::KIND_ACCEPT: begin
            if (slot_free) begin
              emit        = 1'b1;
              emit_event  = lrp_pkg::EV_ACCEPT;
              stack_clear = 1'b1;
              state_next  = lrp_pkg::ST_IDLE;
            end
          end
          lrp_pkg::KIND_REDUCE: begin
            if (32'(act_tgt) >= lrp_pkg::NUM_RULES) begin
              if (slot_free) begin
                emit        = 1'b1;
                emit_event  = lrp_pkg::EV_NOACT;
                stack_clear = 1'b1;
                state_next  = lrp_pkg::ST_IDLE;
              end
            end else if (32'(red_cnt) >= lrp_pkg::REDUCE_LIMIT) begin
              if (slot_free) begin
                emit        = 1'b1;
                emit_event  = lrp_pkg::EV_LIMIT;
                stack_clear = 1'b1;
                state_next  = lrp_pkg::ST_IDLE;
              end
            end else begin
              mem_ctl.rule_re   = 1'b1;
              mem_ctl.rule_addr = lrp_pkg::RULE_AW'(act_tgt);
              rule_num_next     = act_tgt;
              state_next        = lrp_pkg::ST_RULE;
            end
          end
          lrp_pkg::KIND_ERROR: begin
            if (slot_free) begin
              emit        = 1'b1;
              emit_event  = lrp_pkg::EV_NOACT;
              stack_clear = 1'b1;
              state_next  = lrp_pkg::ST_IDLE;
            end
          end
        endcase
      end

      lrp_pkg::ST_RULE: begin
        if (32'(rule_len) > 32'(level) - 32'd1) begin
          if (slot_free) begin
            emit        = 1'b1;
            emit_event  = lrp_pkg::EV_UNDER;
            stack_clear = 1'b1;
            state_next  = lrp_pkg::ST_IDLE;
          end
        end else begin
          level_next       = pop_level;
          mem_ctl.stk_re   = 1'b1;
          mem_ctl.stk_addr = lrp_pkg::SP_AW'(pop_level - lrp_pkg::LVL_W'(1));
          below_zero_next  = (pop_level == lrp_pkg::LVL_W'(1));
          lhs_next         = mem_rd.rule_rd[lrp_pkg::SYM_W-1:0];
          state_next       = lrp_pkg::ST_BELOW;
        end
      end

      lrp_pkg::ST_BELOW: begin
        idx_req.row       = below_val;
        idx_req.col       = lhs;
        idx_req.sel_goto  = 1'b1;
        mem_ctl.goto_re   = 1'b1;
        mem_ctl.goto_addr = idx_rsp.addr[lrp_pkg::GOTO_AW-1:0];
        look_ok_next      = idx_rsp.ok;
        below_next        = below_val;
        state_next        = lrp_pkg::ST_GOTO;
      end

      lrp_pkg::ST_GOTO: begin
        idx_req.row      = g_tgt;
        idx_req.col      = tok;
        idx_req.sel_goto = 1'b0;
        if (slot_free) begin
          emit = 1'b1;
          if (!g_ok) begin
            emit_event  = lrp_pkg::EV_NOGOTO;
            emit_number = below;
            stack_clear = 1'b1;
            state_next  = lrp_pkg::ST_IDLE;
          end else begin
            mem_ctl.stk_we   = 1'b1;
            mem_ctl.stk_addr = lrp_pkg::SP_AW'(level);
            mem_ctl.stk_wd   = g_tgt;
            level_next       = level + lrp_pkg::LVL_W'(1);
            top_next         = g_tgt;
            red_cnt_next     = red_cnt + lrp_pkg::RED_W'(1);
            emit_event       = lrp_pkg::EV_REDUCE;
            emit_number      = rule_num;
            emit_top         = g_tgt;
            emit_last        = 1'b0;
            // retry the same token from the new top
            mem_ctl.act_re   = 1'b1;
            mem_ctl.act_addr = idx_rsp.addr[lrp_pkg::ACT_AW-1:0];
            look_ok_next     = idx_rsp.ok;
            state_next       = lrp_pkg::ST_ACT;
          end
        end
      end

      default: begin
        state_next = lrp_pkg::ST_IDLE;
      end
    endcase

    if (stack_clear) begin
      level_next = lrp_pkg::LVL_W'(1);
      top_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= lrp_pkg::LVL_W'(1);
      top        <= '0;
      out_valid  <= 1'b0;
    end else begin
      level <= level_next;
      top   <= top_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok        <= tok_next;
    red_cnt    <= red_cnt_next;
    rule_num   <= rule_num_next;
    lhs        <= lhs_next;
    below      <= below_next;
    below_zero <= below_zero_next;
    look_ok    <= look_ok_next;
    if (emit) begin
      out_event <= emit_event;
      number    <= emit_number;
      top_state <= emit_top;
      last      <= emit_last;
    end
  end

endmodule

@@ test/lr_table_parser_driver_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for lr_table_parser_driver_top: loads parse tables, sends tokens
// and checks every parser event against a scoreboard that walks the same tables.
// Depends on lrp_pkg and the parser driver RTL; needs no files or arguments.

module lr_table_parser_driver_top_tb;
  import lrp_pkg::*;

  // The longest quiet stretch in a correct run is one receiver stall at 86 % idle plus
  // one parser step; STALL_LIMIT is far beyond any plausible stall.
  localparam int STALL_LIMIT  = 4000;
  // Longest token: action read, then rule/stack/goto/action per reduction to the limit.
  localparam int DRAIN_CYCLES = 2 + 4 * (REDUCE_LIMIT + 1);

  typedef struct {
    mode_t              mode;
    logic [STATE_W-1:0] table_state;
    logic [SYM_W-1:0]   table_symbol;
    kind_t              action_kind;
    logic [STATE_W-1:0] action_target;
    logic [STATE_W-1:0] goto_target;
    logic               goto_valid;
    logic [STATE_W-1:0] rule_index;
    logic [LEN_W-1:0]   rule_length;
    logic [SYM_W-1:0]   rule_lhs;
    logic [SYM_W-1:0]   token_kind;
  } parse_req_t;

  typedef struct {
    event_t             ev;
    logic [STATE_W-1:0] number;
    logic [STATE_W-1:0] top;
    logic               last;
  } parse_event_t;

  // Which store a token walk would read before it has been written
  typedef enum int {
    GAP_NONE,
    GAP_ACTION,
    GAP_RULE,
    GAP_GOTO
  } table_gap_t;

  // Mirror of the parse tables and stack; holds the events still owed by the block.
  class parse_event_board;
    logic [ACT_W-1:0]   action_tab [ACT_DEPTH];
    logic [GOTO_W-1:0]  goto_tab   [GOTO_DEPTH];
    logic [RULE_W-1:0]  rule_tab   [RULE_DEPTH];
    bit                 action_set [ACT_DEPTH];
    bit                 goto_set   [GOTO_DEPTH];
    bit                 rule_set   [RULE_DEPTH];
    logic [STATE_W-1:0] stack_mem  [STACK_DEPTH];
    int                 stack_level;
    parse_event_t       pending_events [$];
    int                 errors;

    function new();
      clear_stack();
      errors = 0;
    endfunction

    function void clear_stack();
      foreach (stack_mem[i]) stack_mem[i] = '0;
      stack_level = 1;
    endfunction

    function logic [STATE_W-1:0] top_of_stack();
      return stack_mem[stack_level - 1];
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    // Walk one token through the tables. Stop at the first unwritten entry and name it
    // (returns 1). With commit set, queue the events and keep the new stack.
    function bit walk_token(input logic [SYM_W-1:0] tok, input bit commit,
                            output table_gap_t gap, output int gap_addr);
      logic [STATE_W-1:0] stk [STACK_DEPTH];
      int                 level;
      int                 reductions;
      int                 a_idx;
      int                 g_idx;
      logic [STATE_W-1:0] top;
      logic [STATE_W-1:0] tgt;
      logic [STATE_W-1:0] below;
      kind_t              kind;
      logic [LEN_W-1:0]   len;
      logic [SYM_W-1:0]   lhs;
      bit                 done;
      bit                 wipe;
      parse_event_t       walk [$];
      stk        = stack_mem;
      level      = stack_level;
      reductions = 0;
      done       = 1'b0;
      wipe       = 1'b0;
      gap        = GAP_NONE;
      gap_addr   = 0;
      while (!done) begin
        top   = stk[level - 1];
        a_idx = int'(top) * NUM_TERMINALS + int'(tok);
        if (!action_set[a_idx]) begin
          gap      = GAP_ACTION;
          gap_addr = a_idx;
          return 1'b1;
        end
        kind = kind_t'(action_tab[a_idx][ACT_W-1:STATE_W]);
        tgt  = action_tab[a_idx][STATE_W-1:0];
        case (kind)
          KIND_SHIFT: begin
            if (level >= STACK_DEPTH) begin
              walk.insert(walk.size(), parse_event_t'{EV_OVER, top, '0, 1'b1});
              wipe = 1'b1;
            end else begin
              stk[level] = tgt;
              level++;
              walk.insert(walk.size(), parse_event_t'{EV_SHIFT, tgt, tgt, 1'b1});
            end
            done = 1'b1;
          end
          KIND_ACCEPT: begin
            walk.insert(walk.size(), parse_event_t'{EV_ACCEPT, top, '0, 1'b1});
            wipe = 1'b1;
            done = 1'b1;
          end
          KIND_ERROR: begin
            walk.insert(walk.size(), parse_event_t'{EV_NOACT, top, '0, 1'b1});
            wipe = 1'b1;
            done = 1'b1;
          end
          default: begin
            if (reductions >= REDUCE_LIMIT) begin
              walk.insert(walk.size(), parse_event_t'{EV_LIMIT, top, '0, 1'b1});
              wipe = 1'b1;
              done = 1'b1;
            end else if (!rule_set[tgt]) begin
              gap      = GAP_RULE;
              gap_addr = int'(tgt);
              return 1'b1;
            end else begin
              len = rule_tab[tgt][RULE_W-1:SYM_W];
              lhs = rule_tab[tgt][SYM_W-1:0];
              if (int'(len) > level - 1) begin
                walk.insert(walk.size(), parse_event_t'{EV_UNDER, top, '0, 1'b1});
                wipe = 1'b1;
                done = 1'b1;
              end else begin
                level = level - int'(len);
                below = stk[level - 1];
                g_idx = int'(below) * NUM_NONTERMINALS + int'(lhs);
                if (!goto_set[g_idx]) begin
                  gap      = GAP_GOTO;
                  gap_addr = g_idx;
                  return 1'b1;
                end
                if (!goto_tab[g_idx][GOTO_W-1]) begin
                  walk.insert(walk.size(), parse_event_t'{EV_NOGOTO, below, '0, 1'b1});
                  wipe = 1'b1;
                  done = 1'b1;
                end else begin
                  stk[level] = goto_tab[g_idx][STATE_W-1:0];
                  level++;
                  walk.insert(walk.size(), parse_event_t'{EV_REDUCE, tgt,
                                                goto_tab[g_idx][STATE_W-1:0], 1'b0});
                  reductions++;
                end
              end
            end
          end
        endcase
      end
      if (commit) begin
        if (wipe) begin
          clear_stack();
        end else begin
          stack_mem   = stk;
          stack_level = level;
        end
        foreach (walk[i]) pending_events.insert(pending_events.size(), walk[i]);
      end
      return 1'b0;
    endfunction

    // Apply an accepted request: a load writes its entry, a token queues its events.
    function void note_request(parse_req_t r);
      table_gap_t gap;
      int         gap_addr;
      int         idx;
      case (r.mode)
        MODE_ACT_WR: begin
          if (int'(r.table_state) < NUM_STATES && int'(r.table_symbol) < NUM_TERMINALS) begin
            idx             = int'(r.table_state) * NUM_TERMINALS + int'(r.table_symbol);
            action_tab[idx] = {r.action_kind, r.action_target};
            action_set[idx] = 1'b1;
          end
        end
        MODE_GOTO_WR: begin
          if (int'(r.table_state) < NUM_STATES && int'(r.table_symbol) < NUM_NONTERMINALS) begin
            idx           = int'(r.table_state) * NUM_NONTERMINALS + int'(r.table_symbol);
            goto_tab[idx] = {r.goto_valid, r.goto_target};
            goto_set[idx] = 1'b1;
          end
        end
        MODE_RULE_WR: begin
          if (int'(r.rule_index) < NUM_RULES) begin
            rule_tab[r.rule_index] = {r.rule_length, r.rule_lhs};
            rule_set[r.rule_index] = 1'b1;
          end
        end
        default: void'(walk_token(r.token_kind, 1'b1, gap, gap_addr));
      endcase
    endfunction

    task check_result(parse_event_t got);
      parse_event_t want;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event %0d number %0d top %0d last %0d",
                                  got.ev, got.number, got.top, got.last));
      end else begin
        want = pending_events.pop_front();
        if (got.ev !== want.ev || got.number !== want.number ||
            got.top !== want.top || got.last !== want.last)
          report_mismatch($sformatf(
            "event %0d/%0d number %0d/%0d top %0d/%0d last %0d/%0d (got/want)",
            got.ev, want.ev, got.number, want.number, got.top, want.top,
            got.last, want.last));
      end
    endtask

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask
  endclass

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [MODE_W-1:0]  mode          = '0;
  logic [STATE_W-1:0] table_state   = '0;
  logic [SYM_W-1:0]   table_symbol  = '0;
  logic [KIND_W-1:0]  action_kind   = '0;
  logic [STATE_W-1:0] action_target = '0;
  logic [STATE_W-1:0] goto_target   = '0;
  logic               goto_valid    = 1'b0;
  logic [STATE_W-1:0] rule_index    = '0;
  logic [LEN_W-1:0]   rule_length   = '0;
  logic [SYM_W-1:0]   rule_lhs      = '0;
  logic [SYM_W-1:0]   token_kind    = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [EVENT_W-1:0] event_res;
  logic [STATE_W-1:0] number;
  logic [STATE_W-1:0] top_state;
  logic               last;

  int src_idle_pct  = 21;
  int sink_idle_pct = 86;
  int sent_count    = 0;

  parse_event_board sb = new();

  lr_table_parser_driver_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .table_state   (table_state),
    .table_symbol  (table_symbol),
    .action_kind   (action_kind),
    .action_target (action_target),
    .goto_target   (goto_target),
    .goto_valid    (goto_valid),
    .rule_index    (rule_index),
    .rule_length   (rule_length),
    .rule_lhs      (rule_lhs),
    .token_kind    (token_kind),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_res     (event_res),
    .number        (number),
    .top_state     (top_state),
    .last          (last)
  );

  always #1 clk = ~clk;

  // Result side: take an event whenever valid meets ready, then draw next cycle's ready.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(parse_event_t'{event_t'(event_res), number, top_state, last});
    out_ready <= !rst && ($urandom_range(99) >= sink_idle_pct);
  end

  // Mostly small states and rules so that parses revisit the same table entries.
  function automatic logic [STATE_W-1:0] pick_small();
    if ($urandom_range(99) < 80) return STATE_W'($urandom_range(7));
    return STATE_W'($urandom_range(255));
  endfunction

  function automatic logic [SYM_W-1:0] pick_token();
    if ($urandom_range(99) < 88) return SYM_W'($urandom_range(5));
    return SYM_W'($urandom_range(63));
  endfunction

  // Favour shifts and reductions; accept and error end the parse.
  function automatic kind_t pick_kind();
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) return KIND_SHIFT;
    if (sel < 80) return KIND_REDUCE;
    if (sel < 90) return KIND_ACCEPT;
    return KIND_ERROR;
  endfunction

  // Fill every field at random so that unused payload bits toggle too.
  function automatic parse_req_t random_fields();
    parse_req_t r;
    r.mode          = mode_t'(MODE_W'($urandom_range(3)));
    r.table_state   = STATE_W'($urandom_range(255));
    r.table_symbol  = SYM_W'($urandom_range(63));
    r.action_kind   = kind_t'(KIND_W'($urandom_range(3)));
    r.action_target = STATE_W'($urandom_range(255));
    r.goto_target   = STATE_W'($urandom_range(255));
    r.goto_valid    = 1'($urandom_range(1));
    r.rule_index    = STATE_W'($urandom_range(255));
    r.rule_length   = LEN_W'($urandom_range(15));
    r.rule_lhs      = SYM_W'($urandom_range(63));
    r.token_kind    = SYM_W'($urandom_range(63));
    return r;
  endfunction

  // Idle at random, then raise valid with the payload and hold both until the request
  // is taken. Valid is left high on return so that a back-to-back request never sees
  // two assignments to it in one step.
  task automatic send_request(parse_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= r.mode;
    table_state   <= r.table_state;
    table_symbol  <= r.table_symbol;
    action_kind   <= r.action_kind;
    action_target <= r.action_target;
    goto_target   <= r.goto_target;
    goto_valid    <= r.goto_valid;
    rule_index    <= r.rule_index;
    rule_length   <= r.rule_length;
    rule_lhs      <= r.rule_lhs;
    token_kind    <= r.token_kind;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
    sent_count++;
  endtask

  task automatic load_action(logic [STATE_W-1:0] st, logic [SYM_W-1:0] sym, kind_t kind,
                             logic [STATE_W-1:0] tgt);
    parse_req_t r;
    r               = random_fields();
    r.mode          = MODE_ACT_WR;
    r.table_state   = st;
    r.table_symbol  = sym;
    r.action_kind   = kind;
    r.action_target = tgt;
    send_request(r);
  endtask

  task automatic load_goto(logic [STATE_W-1:0] st, logic [SYM_W-1:0] sym, logic ok,
                           logic [STATE_W-1:0] tgt);
    parse_req_t r;
    r              = random_fields();
    r.mode         = MODE_GOTO_WR;
    r.table_state  = st;
    r.table_symbol = sym;
    r.goto_valid   = ok;
    r.goto_target  = tgt;
    send_request(r);
  endtask

  task automatic load_rule(logic [STATE_W-1:0] idx, logic [LEN_W-1:0] len,
                           logic [SYM_W-1:0] lhs);
    parse_req_t r;
    r             = random_fields();
    r.mode        = MODE_RULE_WR;
    r.rule_index  = idx;
    r.rule_length = len;
    r.rule_lhs    = lhs;
    send_request(r);
  endtask

  // Load every entry the token would read before it is written, with random content;
  // each load may open a deeper walk, so repeat until the walk is clean.
  task automatic fill_table_gaps(logic [SYM_W-1:0] tok);
    table_gap_t gap;
    int         addr;
    while (sb.walk_token(tok, 1'b0, gap, addr)) begin
      case (gap)
        GAP_ACTION:
          load_action(STATE_W'(addr / NUM_TERMINALS), SYM_W'(addr % NUM_TERMINALS),
                      pick_kind(), pick_small());
        GAP_RULE:
          load_rule(STATE_W'(addr),
                    ($urandom_range(99) < 85) ? LEN_W'($urandom_range(2))
                                              : LEN_W'($urandom_range(15)),
                    ($urandom_range(99) < 85) ? SYM_W'($urandom_range(3))
                                              : SYM_W'($urandom_range(63)));
        default:
          load_goto(STATE_W'(addr / NUM_NONTERMINALS), SYM_W'(addr % NUM_NONTERMINALS),
                    $urandom_range(99) < 92, pick_small());
      endcase
    end
  endtask

  task automatic send_token(logic [SYM_W-1:0] tok);
    parse_req_t r;
    fill_table_gaps(tok);
    r            = random_fields();
    r.mode       = MODE_TOKEN;
    r.token_kind = tok;
    send_request(r);
  endtask

  // Mostly well-formed parses over a small table region; the rest rewrites live
  // entries mid-parse or scatters random loads across the whole table space.
  task automatic random_phase(int n_items);
    int         stop_at;
    int         sel;
    parse_req_t noise;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 80) begin
        send_token(pick_token());
      end else if (sel < 90) begin
        load_action(pick_small(), pick_token(), pick_kind(), pick_small());
      end else begin
        noise      = random_fields();
        noise.mode = mode_t'(MODE_W'($urandom_range(2)));
        send_request(noise);
      end
    end
  endtask

  initial begin
    logic [SYM_W-1:0]   deep_tok;
    logic [STATE_W-1:0] deep_state;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Plain grammar: shift, then a reduce of length one and an accept on the same token.
    load_action(8'd0, 6'd1, KIND_SHIFT, 8'd5);
    load_action(8'd5, 6'd2, KIND_REDUCE, 8'd3);
    load_rule(8'd3, 4'd1, 6'd2);
    load_goto(8'd0, 6'd2, 1'b1, 8'd7);
    load_action(8'd7, 6'd2, KIND_ACCEPT, 8'd0);
    send_token(6'd1);
    send_token(6'd2);

    // Error action on the highest token id.
    load_action(8'd0, 6'd63, KIND_ERROR, 8'd255);
    send_token(6'd63);

    // Reduce to the highest nonterminal whose goto entry is marked invalid.
    load_action(8'd0, 6'd3, KIND_REDUCE, 8'd10);
    load_rule(8'd10, 4'd0, 6'd63);
    load_goto(8'd0, 6'd63, 1'b0, 8'd255);
    send_token(6'd3);

    // Longest rule on the last rule slot pops past the bottom entry.
    load_action(8'd0, 6'd4, KIND_REDUCE, 8'd255);
    load_rule(8'd255, 4'd15, 6'd0);
    send_token(6'd4);

    // Empty rule that returns to its own state: reduces until the limit trips.
    load_action(8'd0, 6'd5, KIND_REDUCE, 8'd20);
    load_rule(8'd20, 4'd0, 6'd1);
    load_goto(8'd0, 6'd1, 1'b1, 8'd0);
    send_token(6'd5);

    // Shift into the top state, then accept from it.
    load_action(8'd0, 6'd6, KIND_SHIFT, 8'd255);
    load_action(8'd255, 6'd6, KIND_ACCEPT, 8'd128);
    send_token(6'd6);
    send_token(6'd6);

    // Fill the stack with a self-looping shift, then one more shift to overflow it.
    deep_tok   = SYM_W'($urandom_range(6, 63));
    deep_state = sb.top_of_stack();
    load_action(deep_state, deep_tok, KIND_SHIFT, deep_state);
    repeat (STACK_DEPTH + 1 - sb.stack_level) send_token(deep_tok);
    random_phase(20);

    src_idle_pct  = 86;
    sink_idle_pct = 21;
    random_phase(26);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    random_phase(26);

    // Drop valid, wait for every owed event, then watch for strays.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog: end the run once nothing has moved on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule
